@@ rtl/cdt_pkg.sv @@
// Shared constants and types for the corner dwell trigger.
package cdt_pkg;

   parameter int EDGE_TOLERANCE = 1;     // pixels of slack at each screen edge
   parameter int COOLDOWN_MS    = 1000;  // minimum time between two firings
   parameter int POS_W          = 20;    // signed width for edge arithmetic

   parameter int CSR_IDX_W  = 3;
   parameter int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE        = 3'd0,
      CSR_SCREEN_LEFT   = 3'd1,
      CSR_SCREEN_TOP    = 3'd2,
      CSR_SCREEN_WIDTH  = 3'd3,
      CSR_SCREEN_HEIGHT = 3'd4,
      CSR_DWELL_DELAY   = 3'd5,
      CSR_BYPASS_ENABLE = 3'd6,
      CSR_ACTION_MASK   = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      CORNER_NONE = 3'd0,
      CORNER_TL   = 3'd1,
      CORNER_TR   = 3'd2,
      CORNER_BL   = 3'd3,
      CORNER_BR   = 3'd4
   } corner_type;

endpackage

@@ rtl/corner_dwell_trigger.sv @@
// Hot-corner dwell detector: one pointer sample in, one classification result out.
// Path: an accepted req item passes the input register, then the result register, to its rsp item.
// Throughput: one item per cycle while rsp_stall is low; corner/timer state update and result
//   use the same logic (two 32-bit subtracts, compares), so back-to-back items see fresh state.
// Reset (synchronous, active high): pipeline empty, corner none, timers and marks zero,
//   configuration to enable=1, screen 1920x1080 at origin, dwell 300 ms, bypass on, no actions.
module corner_dwell_trigger
   import cdt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // sample channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [15:0]    req_cursor_x,
   input  logic signed [15:0]    req_cursor_y,
   input  logic                  req_cursor_valid,
   input  logic                  req_fullscreen_block,
   input  logic [31:0]           req_now_ms,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_fire,
   output logic                  rsp_silenced,
   output logic [2:0]            rsp_corner,
   // configuration writes
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam logic signed [POS_W-1:0] TOL      = POS_W'(EDGE_TOLERANCE);
   localparam logic        [31:0]      COOLDOWN = 32'(COOLDOWN_MS);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic               cfg_enable_ff;
   logic signed [15:0] cfg_left_ff;
   logic signed [15:0] cfg_top_ff;
   logic [14:0]        cfg_width_ff;
   logic [14:0]        cfg_height_ff;
   logic [15:0]        cfg_dwell_ff;
   logic               cfg_bypass_ff;
   logic [3:0]         cfg_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_enable_ff <= 1'b1;
         cfg_left_ff   <= '0;
         cfg_top_ff    <= '0;
         cfg_width_ff  <= 15'd1920;
         cfg_height_ff <= 15'd1080;
         cfg_dwell_ff  <= 16'd300;
         cfg_bypass_ff <= 1'b1;
         cfg_mask_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ENABLE:        cfg_enable_ff <= csr_wdata[0];
            CSR_SCREEN_LEFT:   cfg_left_ff   <= csr_wdata;
            CSR_SCREEN_TOP:    cfg_top_ff    <= csr_wdata;
            CSR_SCREEN_WIDTH:  cfg_width_ff  <= csr_wdata[14:0];
            CSR_SCREEN_HEIGHT: cfg_height_ff <= csr_wdata[14:0];
            CSR_DWELL_DELAY:   cfg_dwell_ff  <= csr_wdata;
            CSR_BYPASS_ENABLE: cfg_bypass_ff <= csr_wdata[0];
            CSR_ACTION_MASK:   cfg_mask_ff   <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake: the input register moves forward whenever the result
   // register is empty or being drained this cycle.
   // ---------------------------------------------------------------
   logic        in_valid_ff;
   logic signed [15:0] x_ff, y_ff;
   logic        cvalid_ff;
   logic        block_ff;
   logic [31:0] now_ff;

   logic rsp_valid_ff;
   logic rsp_fire_ff, rsp_silenced_ff;
   logic [2:0] rsp_corner_ff;

   logic advance;   // stage 1 item may move into the result register
   logic load_in;   // input register takes a new item

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign load_in   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (load_in) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (load_in) begin
         x_ff      <= req_cursor_x;
         y_ff      <= req_cursor_y;
         cvalid_ff <= req_cursor_valid;
         block_ff  <= req_fullscreen_block;
         now_ff    <= req_now_ms;
      end
   end

   // ---------------------------------------------------------------
   // Corner classification
   // ---------------------------------------------------------------
   logic signed [POS_W-1:0] left_s, top_s, width_s, height_s, x_s, y_s;
   logic signed [POS_W-1:0] right_lim, bottom_lim;
   logic at_left, at_right, at_top, at_bottom;
   corner_type det_corner;

   always_comb begin
      left_s   = {{(POS_W-16){cfg_left_ff[15]}}, cfg_left_ff};
      top_s    = {{(POS_W-16){cfg_top_ff[15]}}, cfg_top_ff};
      width_s  = {{(POS_W-15){1'b0}}, cfg_width_ff};
      height_s = {{(POS_W-15){1'b0}}, cfg_height_ff};
      x_s      = {{(POS_W-16){x_ff[15]}}, x_ff};
      y_s      = {{(POS_W-16){y_ff[15]}}, y_ff};

      // right/bottom = edge + size - 1, then pull in by the tolerance
      right_lim  = left_s + width_s - POS_W'(1) - TOL;
      bottom_lim = top_s + height_s - POS_W'(1) - TOL;

      at_left   = x_s <= left_s + TOL;
      at_right  = x_s >= right_lim;
      at_top    = y_s <= top_s + TOL;
      at_bottom = y_s >= bottom_lim;

      // TL wins over TR, BL, BR on tiny screens
      if (at_left && at_top)          det_corner = CORNER_TL;
      else if (at_right && at_top)    det_corner = CORNER_TR;
      else if (at_left && at_bottom)  det_corner = CORNER_BL;
      else if (at_right && at_bottom) det_corner = CORNER_BR;
      else                            det_corner = CORNER_NONE;
   end

   // ---------------------------------------------------------------
   // Dwell / cooldown decision
   // ---------------------------------------------------------------
   corner_type  corner_ff, corner_in;
   logic [31:0] enter_ff, enter_in;
   logic        done_ff, done_in;
   logic [31:0] last_fire_ff, last_fire_in;
   logic        fired_before_ff, fired_before_in;

   logic        fire_in, silenced_in;
   logic [31:0] elapsed, since_fire;
   logic        has_action, cool;

   always_comb begin
      elapsed    = now_ff - enter_ff;
      since_fire = now_ff - last_fire_ff;
      cool       = !fired_before_ff || (since_fire >= COOLDOWN);

      case (corner_ff)
         CORNER_TL: has_action = cfg_mask_ff[0];
         CORNER_TR: has_action = cfg_mask_ff[1];
         CORNER_BL: has_action = cfg_mask_ff[2];
         CORNER_BR: has_action = cfg_mask_ff[3];
         default:   has_action = 1'b0;
      endcase

      corner_in       = corner_ff;
      enter_in        = enter_ff;
      done_in         = done_ff;
      last_fire_in    = last_fire_ff;
      fired_before_in = fired_before_ff;
      fire_in         = 1'b0;
      silenced_in     = 1'b0;

      if (cfg_enable_ff && cvalid_ff) begin
         if (det_corner != corner_ff) begin
            // new corner: restart the dwell timer
            corner_in = det_corner;
            enter_in  = now_ff;
            done_in   = 1'b0;
         end else if (corner_ff != CORNER_NONE && !done_ff
                      && elapsed >= {16'd0, cfg_dwell_ff}) begin
            if (cfg_bypass_ff && block_ff) begin
               done_in     = 1'b1;
               silenced_in = 1'b1;
            end else if (cool && has_action) begin
               fire_in         = 1'b1;
               done_in         = 1'b1;
               last_fire_in    = now_ff;
               fired_before_in = 1'b1;
            end
            // otherwise the mark stays clear and the test repeats next sample
         end
      end
   end

   logic step;   // stage 1 item is processed this cycle
   assign step = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff       <= CORNER_NONE;
         enter_ff        <= '0;
         done_ff         <= 1'b0;
         last_fire_ff    <= '0;
         fired_before_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (step) begin
            corner_ff       <= corner_in;
            enter_ff        <= enter_in;
            done_ff         <= done_in;
            last_fire_ff    <= last_fire_in;
            fired_before_ff <= fired_before_in;
            rsp_valid_ff    <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_fire_ff     <= fire_in;
         rsp_silenced_ff <= silenced_in;
         rsp_corner_ff   <= corner_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_fire     = rsp_fire_ff;
   assign rsp_silenced = rsp_silenced_ff;
   assign rsp_corner   = rsp_corner_ff;

endmodule

@@ rtl/cdt_checker.sv @@
// Port-level checker for the corner dwell trigger, bound to the top level.
module cdt_checker
   import cdt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_fire,
   input logic                  rsp_silenced,
   input logic [2:0]            rsp_corner
);

   // an item either fires or is silenced, never both
   a_fire_xor_silence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_fire && rsp_silenced))
      else $error("fire and silenced on the same item");

   // firing or silencing needs a corner
   a_event_has_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_fire || rsp_silenced) |-> rsp_corner != CORNER_NONE)
      else $error("event reported with no corner");

   // corner code stays in range
   a_corner_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_corner <= CORNER_BR)
      else $error("corner code out of range");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_fire) && $stable(rsp_silenced)
                                 && $stable(rsp_corner))
      else $error("stalled result changed");

   // input only stalls while a result waits on a stalled receiver
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with the result side free");

endmodule

bind corner_dwell_trigger cdt_checker u_cdt_checker (.*);
